### src/tccc_pkg.sv
package tccc_pkg;

  localparam int unsigned PosW   = 11;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned SurfW  = 6;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned BorderPixels = 2;
  localparam int unsigned TitlePixels  = 20;

  localparam logic [PosW-1:0] CellW    = 11'd8;
  localparam logic [PosW-1:0] CellH    = 11'd16;
  localparam logic [PosW-1:0] OffsetX  = PosW'(BorderPixels);
  localparam logic [PosW-1:0] OffsetY  = PosW'(BorderPixels + TitlePixels);

  localparam logic [ByteW-1:0] CharNewline   = 8'd10;
  localparam logic [ByteW-1:0] CharBackspace = 8'd8;

  localparam logic [PosW-1:0]  ResetContentWidth  = 11'd640;
  localparam logic [PosW-1:0]  ResetContentHeight = 11'd400;
  localparam logic [ByteW-1:0] ResetLeftMargin    = 8'd8;
  localparam logic [ByteW-1:0] ResetTopMargin     = 8'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTENT_WIDTH  = 3'd0,
    CFG_CONTENT_HEIGHT = 3'd1,
    CFG_LEFT_MARGIN    = 3'd2,
    CFG_TOP_MARGIN     = 3'd3,
    CFG_BG_COLOR       = 3'd4,
    CFG_WINDOW_ID      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_SCROLL = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_PRINT,
    KIND_NEWLINE,
    KIND_BACKSPACE
  } kind_e;

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_e;

  typedef struct packed {
    logic [PosW-1:0]  content_width;
    logic [PosW-1:0]  content_height;
    logic [ByteW-1:0] left_margin;
    logic [ByteW-1:0] top_margin;
    logic [ByteW-1:0] background_color;
    logic [SurfW-1:0] window_id;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] char_code;
    logic [ByteW-1:0] text_color;
  } item_t;

  typedef struct packed {
    op_e              op_kind;
    logic [PosW-1:0]  pos_x;
    logic [PosW-1:0]  pos_y;
    logic [ByteW-1:0] glyph;
    logic [ByteW-1:0] paint_color;
    logic [SurfW-1:0] surface;
    logic             last;
  } cmd_t;

endpackage

### src/tccc_front.sv
module tccc_front import tccc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ByteW-1:0] char_code_i,
  input  logic [ByteW-1:0] text_color_i,
  output logic             full_o,
  output item_t            item_o,
  output logic             item_valid_o,
  input  logic             item_take_i
);

  item_t       slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q;
  logic        do_push, do_pop;
  item_t       item_in;

  // classify the character on the way in
  always_comb begin
    item_in.char_code  = char_code_i;
    item_in.text_color = text_color_i;
    if (char_code_i == CharNewline) begin
      item_in.kind = KIND_NEWLINE;
    end else if (char_code_i == CharBackspace) begin
      item_in.kind = KIND_BACKSPACE;
    end else begin
      item_in.kind = KIND_PRINT;
    end
  end

  assign full_o       = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_take_i && item_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/tccc_back.sv
module tccc_back import tccc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  item_t item_i,
  input  logic  item_valid_i,
  output logic  item_take_o,
  output cmd_t  cmd_o,
  output logic  cmd_push_o,
  input  logic  cmd_full_i
);

  phase_e          phase_q, phase_d;
  logic [PosW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;

  logic [PosW-1:0] lm11;
  // printable path
  logic            p_wrap, p_scroll;
  logic [PosW-1:0] p_x1, p_y1, p_y2;
  // newline path
  logic            n_scroll;
  logic [PosW-1:0] n_y1, n_y2;
  // backspace path
  logic            b_home, b_inline;
  logic [12:0]     b_span, b_mag, b_q8, b_nx;
  logic [PosW-1:0] b_x, b_y;
  cmd_t            scroll_cmd, draw_cmd, clear_cmd;

  assign lm11 = {3'b0, cfg_i.left_margin};

  always_comb begin
    p_wrap   = ({1'b0, cur_x_q} + 12'd16) >= {1'b0, cfg_i.content_width};
    p_x1     = p_wrap ? lm11 : cur_x_q;
    p_y1     = p_wrap ? cur_y_q + CellH : cur_y_q;
    p_scroll = ({1'b0, p_y1} + 12'd16) >= {1'b0, cfg_i.content_height};
    p_y2     = p_scroll ? p_y1 - CellH : p_y1;

    n_y1     = cur_y_q + CellH;
    n_scroll = ({1'b0, n_y1} + 12'd16) >= {1'b0, cfg_i.content_height};
    n_y2     = n_scroll ? n_y1 - CellH : n_y1;

    b_home   = (cur_x_q == lm11) && (cur_y_q == {3'b0, cfg_i.top_margin});
    b_inline = cur_x_q >= (lm11 + CellW);
    // last full cell of the previous line, division truncates toward zero
    b_span   = {2'b0, cfg_i.content_width} - {5'b0, cfg_i.left_margin};
    b_mag    = b_span[12] ? (13'd0 - b_span) : b_span;
    b_q8     = b_span[12] ? (13'd0 - {b_mag[12:3], 3'b0}) : {b_mag[12:3], 3'b0};
    b_nx     = b_q8 - 13'd8 + {5'b0, cfg_i.left_margin};
    b_x      = b_inline ? cur_x_q - CellW : b_nx[PosW-1:0];
    b_y      = b_inline ? cur_y_q : cur_y_q - CellH;

    scroll_cmd.op_kind     = OP_SCROLL;
    scroll_cmd.pos_x       = '0;
    scroll_cmd.pos_y       = (item_i.kind == KIND_NEWLINE) ? n_y1 : p_y1;
    scroll_cmd.glyph       = '0;
    scroll_cmd.paint_color = cfg_i.background_color;
    scroll_cmd.surface     = cfg_i.window_id;
    scroll_cmd.last        = (item_i.kind == KIND_NEWLINE);

    draw_cmd.op_kind     = OP_DRAW;
    draw_cmd.pos_x       = p_x1 + OffsetX;
    draw_cmd.pos_y       = p_y2 + OffsetY;
    draw_cmd.glyph       = item_i.char_code;
    draw_cmd.paint_color = item_i.text_color;
    draw_cmd.surface     = cfg_i.window_id;
    draw_cmd.last        = 1'b1;

    clear_cmd.op_kind     = OP_CLEAR;
    clear_cmd.pos_x       = b_x + OffsetX;
    clear_cmd.pos_y       = b_y + OffsetY;
    clear_cmd.glyph       = '0;
    clear_cmd.paint_color = cfg_i.background_color;
    clear_cmd.surface     = cfg_i.window_id;
    clear_cmd.last        = 1'b1;
  end

  always_comb begin
    phase_d     = phase_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    item_take_o = 1'b0;
    cmd_push_o  = 1'b0;
    cmd_o       = draw_cmd;
    unique case (phase_q)
      PH_FIRST: begin
        if (item_valid_i && !cmd_full_i) begin
          unique case (item_i.kind)
            KIND_PRINT: begin
              cmd_push_o = 1'b1;
              if (p_scroll) begin
                // scroll first, draw in the second phase
                cmd_o   = scroll_cmd;
                phase_d = PH_SECOND;
              end else begin
                item_take_o = 1'b1;
                cur_x_d     = p_x1 + CellW;
                cur_y_d     = p_y2;
              end
            end
            KIND_NEWLINE: begin
              cmd_o       = scroll_cmd;
              cmd_push_o  = n_scroll;
              item_take_o = 1'b1;
              cur_x_d     = lm11;
              cur_y_d     = n_y2;
            end
            KIND_BACKSPACE: begin
              item_take_o = 1'b1;
              cmd_o       = clear_cmd;
              if (!b_home) begin
                cmd_push_o = 1'b1;
                cur_x_d    = b_x;
                cur_y_d    = b_y;
              end
            end
            default: begin
              item_take_o = 1'b1;
            end
          endcase
        end
      end
      PH_SECOND: begin
        if (!cmd_full_i) begin
          cmd_push_o  = 1'b1;
          item_take_o = 1'b1;
          cur_x_d     = p_x1 + CellW;
          cur_y_d     = p_y2;
          phase_d     = PH_FIRST;
        end
      end
      default: begin
        phase_d = PH_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_FIRST;
      cur_x_q <= {3'b0, ResetLeftMargin};
      cur_y_q <= {3'b0, ResetTopMargin};
    end else begin
      phase_q <= phase_d;
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
    end
  end

endmodule

### src/tccc_cmd_queue.sv
module tccc_cmd_queue import tccc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_push_i,
  output logic cmd_full_o,
  output cmd_t head_o,
  output logic empty_o,
  input  logic pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign cmd_full_o = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign head_o     = slot_q[rd_ptr_q];
  assign do_push    = cmd_push_i && !cmd_full_o;
  assign do_pop     = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

### src/text_console_cursor_control.sv
// Text cursor for one window of 8x16 character cells.
// Input channel: push / full, one character (char_code_i, text_color_i) per
//   request; a request is taken at a clock edge with push high and full low.
// Result channel: empty / pop, one drawing command per request; the oldest
//   command sits on the result ports while empty is low and leaves on a clock
//   edge with pop high. A character yields zero, one or two commands; last_o
//   marks its final one.
// Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
//   ready is always high. Write only while the block is idle.
// Order: the first command of a character is written into the result queue by the
//   cursor engine; a draw that follows a scroll is sent from the engine's second phase.
// Throughput: one character per cycle while the result queue has room; a character
//   that scrolls and then draws holds the cursor engine until both of its commands are
//   out, since the engine emits one command per cycle into the result queue.
// Reset: registers return to their defaults and the cursor goes home
//   (left 8, top 8); both queues empty.
// Stall: two-entry queues on each side; when pop stays low the result queue
//   fills, the engine holds, the input queue fills and full rises.
module text_console_cursor_control import tccc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [ByteW-1:0]   char_code_i,
  input  logic [ByteW-1:0]   text_color_i,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         op_kind_o,
  output logic [PosW-1:0]    pos_x_o,
  output logic [PosW-1:0]    pos_y_o,
  output logic [ByteW-1:0]   glyph_o,
  output logic [ByteW-1:0]   paint_color_o,
  output logic [SurfW-1:0]   surface_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [PosW-1:0]    cfg_data_i
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, item_take;
  cmd_t  cmd, head;
  logic  cmd_push, cmd_full;

  assign cfg_ready_o = 1'b1;

  // configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.content_width    <= ResetContentWidth;
      cfg_q.content_height   <= ResetContentHeight;
      cfg_q.left_margin      <= ResetLeftMargin;
      cfg_q.top_margin       <= ResetTopMargin;
      cfg_q.background_color <= '0;
      cfg_q.window_id        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CONTENT_WIDTH:  cfg_q.content_width    <= cfg_data_i;
        CFG_CONTENT_HEIGHT: cfg_q.content_height   <= cfg_data_i;
        CFG_LEFT_MARGIN:    cfg_q.left_margin      <= cfg_data_i[ByteW-1:0];
        CFG_TOP_MARGIN:     cfg_q.top_margin       <= cfg_data_i[ByteW-1:0];
        CFG_BG_COLOR:       cfg_q.background_color <= cfg_data_i[ByteW-1:0];
        CFG_WINDOW_ID:      cfg_q.window_id        <= cfg_data_i[SurfW-1:0];
        default: ;
      endcase
    end
  end

  // front: take and classify characters
  tccc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .char_code_i  (char_code_i),
    .text_color_i (text_color_i),
    .full_o       (full),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_take_i  (item_take)
  );

  // back: move the cursor and emit commands
  tccc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .cmd_o        (cmd),
    .cmd_push_o   (cmd_push),
    .cmd_full_i   (cmd_full)
  );

  // result queue toward the pixel engine
  tccc_cmd_queue u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_push_i (cmd_push),
    .cmd_full_o (cmd_full),
    .head_o     (head),
    .empty_o    (empty),
    .pop_i      (pop)
  );

  assign op_kind_o     = head.op_kind;
  assign pos_x_o       = head.pos_x;
  assign pos_y_o       = head.pos_y;
  assign glyph_o       = head.glyph;
  assign paint_color_o = head.paint_color;
  assign surface_o     = head.surface;
  assign last_o        = head.last;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import tccc_pkg::*;

  localparam int NumPhases     = 10;
  localparam int ItemsPerPhase = 170;
  localparam int HoldPhase     = 3;
  localparam int RxHoldCycles  = 300;
  localparam int SettleCycles  = 16;
  localparam int MaxReports    = 10;
  localparam int LimitCycles   = 1000000;

  // Keep the expected command stream: a cursor tracker plus the queue of
  // commands still owed by the block, oldest first.
  class cursor_scoreboard;
    cfg_t            regs;
    logic [PosW-1:0] cur_x;
    logic [PosW-1:0] cur_y;
    cmd_t            pending_cmds[$];
    int              failures;

    function new();
      regs.content_width    = ResetContentWidth;
      regs.content_height   = ResetContentHeight;
      regs.left_margin      = ResetLeftMargin;
      regs.top_margin       = ResetTopMargin;
      regs.background_color = '0;
      regs.window_id        = '0;
      cur_x                 = PosW'(ResetLeftMargin);
      cur_y                 = PosW'(ResetTopMargin);
      failures              = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [PosW-1:0] val);
      case (idx)
        CFG_CONTENT_WIDTH:  regs.content_width    = val;
        CFG_CONTENT_HEIGHT: regs.content_height   = val;
        CFG_LEFT_MARGIN:    regs.left_margin      = val[ByteW-1:0];
        CFG_TOP_MARGIN:     regs.top_margin       = val[ByteW-1:0];
        CFG_BG_COLOR:       regs.background_color = val[ByteW-1:0];
        CFG_WINDOW_ID:      regs.window_id        = val[SurfW-1:0];
        default: ;
      endcase
    endfunction

    function void emit(op_e op, logic [PosW-1:0] x, logic [PosW-1:0] y,
                       logic [ByteW-1:0] g, logic [ByteW-1:0] col, logic last);
      cmd_t c;
      c.op_kind     = op;
      c.pos_x       = x;
      c.pos_y       = y;
      c.glyph       = g;
      c.paint_color = col;
      c.surface     = regs.window_id;
      c.last        = last;
      pending_cmds.push_back(c);
    endfunction

    // Scroll carries the raw cursor row, taken before the row steps back.
    function void scroll_if_full(logic last);
      if (int'(cur_y) + int'(CellH) >= int'(regs.content_height)) begin
        emit(OP_SCROLL, '0, cur_y, '0, regs.background_color, last);
        cur_y = cur_y - CellH;
      end
    endfunction

    function void note_char(logic [ByteW-1:0] ch, logic [ByteW-1:0] col);
      int span;
      int nx;
      if (ch == CharNewline) begin
        cur_y = cur_y + CellH;
        cur_x = PosW'(regs.left_margin);
        scroll_if_full(1'b1);
      end else if (ch == CharBackspace) begin
        if (cur_x == PosW'(regs.left_margin) && cur_y == PosW'(regs.top_margin))
          return;
        if (int'(cur_x) >= int'(regs.left_margin) + int'(CellW)) begin
          cur_x = cur_x - CellW;
        end else begin
          // back to the last full cell of the previous line; span may go negative
          span  = int'(regs.content_width) - int'(regs.left_margin);
          nx    = (span / int'(CellW) - 1) * int'(CellW) + int'(regs.left_margin);
          cur_x = nx[PosW-1:0];
          cur_y = cur_y - CellH;
        end
        emit(OP_CLEAR, cur_x + OffsetX, cur_y + OffsetY, '0, regs.background_color, 1'b1);
      end else begin
        // wrap when the cell after this one would not fit
        if (int'(cur_x) + 2 * int'(CellW) >= int'(regs.content_width)) begin
          cur_x = PosW'(regs.left_margin);
          cur_y = cur_y + CellH;
        end
        scroll_if_full(1'b0);
        emit(OP_DRAW, cur_x + OffsetX, cur_y + OffsetY, ch, col, 1'b1);
        cur_x = cur_x + CellW;
      end
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t want;
      if (pending_cmds.size() == 0) begin
        failures++;
        if (failures <= MaxReports)
          $display("unexpected command: op=%0d x=%0d y=%0d glyph=%0d color=%0d surf=%0d last=%0d",
                   got.op_kind, got.pos_x, got.pos_y, got.glyph, got.paint_color,
                   got.surface, got.last);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.op_kind !== want.op_kind || got.pos_x !== want.pos_x ||
          got.pos_y !== want.pos_y || got.glyph !== want.glyph ||
          got.paint_color !== want.paint_color || got.surface !== want.surface ||
          got.last !== want.last) begin
        failures++;
        if (failures <= MaxReports)
          $display("command mismatch: expected op=%0d x=%0d y=%0d glyph=%0d color=%0d surf=%0d last=%0d, got op=%0d x=%0d y=%0d glyph=%0d color=%0d surf=%0d last=%0d",
                   want.op_kind, want.pos_x, want.pos_y, want.glyph, want.paint_color,
                   want.surface, want.last, got.op_kind, got.pos_x, got.pos_y,
                   got.glyph, got.paint_color, got.surface, got.last);
      end
    endfunction

    function int outstanding();
      return pending_cmds.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [ByteW-1:0]   char_code_i;
  logic [ByteW-1:0]   text_color_i;
  logic               empty;
  logic               pop;
  logic [1:0]         op_kind_o;
  logic [PosW-1:0]    pos_x_o;
  logic [PosW-1:0]    pos_y_o;
  logic [ByteW-1:0]   glyph_o;
  logic [ByteW-1:0]   paint_color_o;
  logic [SurfW-1:0]   surface_o;
  logic               last_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [PosW-1:0]    cfg_data_i;

  // Pacing knobs shared between the stimulus and the result side.
  bit tx_calm;
  bit rx_calm;
  bit rx_hold_req;
  int cycle_count;

  cursor_scoreboard sb = new();

  text_console_cursor_control u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .text_color_i  (text_color_i),
    .empty         (empty),
    .pop           (pop),
    .op_kind_o     (op_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .glyph_o       (glyph_o),
    .paint_color_o (paint_color_o),
    .surface_o     (surface_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run: far beyond the slowest legal pacing of every request.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Plain text dominates; newline and backspace are sprinkled in.
  function automatic logic [ByteW-1:0] next_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12)
      return CharNewline;
    else if (r < 25)
      return CharBackspace;
    return ByteW'($urandom_range(0, (1 << ByteW) - 1));
  endfunction

  // First two phases hit the register extremes; the rest favor small windows
  // so that wrap, scroll and line-start backspace come up often.
  function automatic cfg_t pick_window(int p);
    cfg_t c;
    if (p == 0) begin
      c = '1;
    end else if (p == 1) begin
      c = '0;
    end else begin
      c.content_width = ($urandom_range(0, 3) == 0) ?
                        PosW'($urandom_range(0, (1 << PosW) - 1)) :
                        PosW'($urandom_range(16, 160));
      c.content_height = ($urandom_range(0, 3) == 0) ?
                         PosW'($urandom_range(0, (1 << PosW) - 1)) :
                         PosW'($urandom_range(16, 200));
      c.left_margin = ($urandom_range(0, 3) == 0) ?
                      ByteW'($urandom_range(0, (1 << ByteW) - 1)) :
                      ByteW'($urandom_range(0, 24));
      c.top_margin = ($urandom_range(0, 3) == 0) ?
                     ByteW'($urandom_range(0, (1 << ByteW) - 1)) :
                     ByteW'($urandom_range(0, 24));
      c.background_color = ByteW'($urandom_range(0, (1 << ByteW) - 1));
      c.window_id        = SurfW'($urandom_range(0, (1 << SurfW) - 1));
    end
    return c;
  endfunction

  // Offer one character; hold the request until the block takes it, then
  // note it on the scoreboard. Leave push high so back-to-back requests flow.
  task automatic send_char(input logic [ByteW-1:0] ch, input logic [ByteW-1:0] col);
    int gap;
    gap = tx_calm ? 0 : draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push         <= 1'b1;
    char_code_i  <= ch;
    text_color_i <= col;
    do @(posedge clk_i); while (full);
    sb.note_char(ch, col);
  endtask

  // Drop push after the last request of a burst.
  task automatic end_burst();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Wait for every owed command, then give silent characters time to leave
  // the pipeline before the registers change.
  task automatic settle();
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PosW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Poke the unused indexes with junk first, then load every real register.
  task automatic program_window(input cfg_t c);
    for (int i = int'(CFG_WINDOW_ID) + 1; i < (1 << CfgIdxW); i++)
      write_reg(CfgIdxW'(i), PosW'($urandom_range(0, (1 << PosW) - 1)));
    write_reg(CFG_CONTENT_WIDTH,  c.content_width);
    write_reg(CFG_CONTENT_HEIGHT, c.content_height);
    write_reg(CFG_LEFT_MARGIN,    PosW'(c.left_margin));
    write_reg(CFG_TOP_MARGIN,     PosW'(c.top_margin));
    write_reg(CFG_BG_COLOR,       PosW'(c.background_color));
    write_reg(CFG_WINDOW_ID,      PosW'(c.window_id));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: pop changes only at the falling edge. Honor one long hold
  // when asked so the block backs up into full, otherwise stall at random.
  initial begin : result_pacer
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    pop        = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk_i);
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!rx_calm)
          stall_left = draw_gap();
      end
    end
  end

  // Compare every command that leaves on a pop against the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_cmd(cmd_t'{op_e'(op_kind_o), pos_x_o, pos_y_o, glyph_o,
                          paint_color_o, surface_o, last_o});
  end

  initial begin : stimulus
    cfg_t win;
    push         = 1'b0;
    char_code_i  = '0;
    text_color_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    rx_hold_req  = 1'b0;
    cycle_count  = 0;
    rst_ni       = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed, reset window: cursor starts at home.
    send_char(CharBackspace, 8'h00);   // home: dropped, no command
    send_char(8'h00, 8'hFF);           // glyph and color extremes
    send_char(8'hFF, 8'h00);
    send_char(8'h55, 8'hAA);
    send_char(CharBackspace, 8'h11);   // erase inside the line
    send_char(CharNewline, 8'h22);     // plain line feed, nothing emitted
    send_char(CharBackspace, 8'h33);   // line start: back to previous line end
    send_char(8'hAA, 8'h55);           // wraps to the next line
    end_burst();
    settle();

    // Directed, tiny window: plain draws, newlines that do not scroll and a
    // backspace across a line boundary.
    win.content_width    = PosW'(48);
    win.content_height   = PosW'(56);
    win.left_margin      = '0;
    win.top_margin       = '0;
    win.background_color = '1;
    win.window_id        = '1;
    program_window(win);
    send_char(8'h41, 8'h01);
    send_char(8'h42, 8'h02);
    send_char(8'h43, 8'h03);
    send_char(8'h44, 8'h04);           // fits on the line: no wrap, no scroll
    send_char(CharNewline, 8'h05);     // plain line feed, nothing emitted
    send_char(CharBackspace, 8'h06);   // line start
    send_char(CharBackspace, 8'h07);
    send_char(CharNewline, 8'h08);
    send_char(CharNewline, 8'h09);
    send_char(8'h7E, 8'h80);
    end_burst();
    settle();

    // Random phases, each with its own window and pacing.
    for (int p = 0; p < NumPhases; p++) begin
      program_window(pick_window(p));
      tx_calm = (p == HoldPhase) || ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if (p == HoldPhase)
        rx_hold_req = 1'b1;
      for (int i = 0; i < ItemsPerPhase; i++)
        send_char(next_char(), ByteW'($urandom_range(0, (1 << ByteW) - 1)));
      end_burst();
      settle();
    end

    if (sb.failures == 0 && sb.outstanding() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
